// ===== hdl/cdq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_pkg
// Command codes and item types shared by the circular deque core.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_NONE       = 3'd4;

  localparam int WORD_W = 32;
  localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] data_in;
  } cmd_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic                     is_empty;
    logic                     is_full;
  } res_item_t;

endpackage : cdq_pkg
`default_nettype wire

// ===== hdl/cdq_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : cdq_ram
`default_nettype wire

// ===== hdl/circular_deque_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of signed 32-bit words in a circular RAM.
// ---------------------------------------------------------------------------
// The front and back words are cached in registers, so a push or query is
// accepted and its result is in the output register at the next edge. A
// successful pop passes through S_WAIT before its result is loaded, as the
// slot RAM has registered read data: the popped word comes from the cache,
// and the RAM read fetches the word that becomes the new front or back. The
// next item is taken while a result waits, as long as the output register
// is freed in that cycle. No clearing pass follows reset.
// ---------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_item_t cmd_item,
  output logic           res_valid,
  input  wire logic      res_ready,
  output res_item_t      res_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  logic                     state, state_next;
  logic [AW-1:0]            head, head_next;
  logic [AW-1:0]            tail, tail_next;
  logic [CW-1:0]            count, count_next;
  logic signed [WORD_W-1:0] front, front_next;
  logic signed [WORD_W-1:0] back, back_next;
  logic signed [WORD_W-1:0] pend_pop, pend_pop_next;
  logic                     pend_front, pend_front_next;
  res_item_t                res_next;
  logic                     res_load;

  logic                     go, full, empty, empty_next, pop_go;
  logic                     we, re;
  logic [AW-1:0]            waddr, raddr;
  logic [WORD_W-1:0]        rdata;

  assign cmd_ready = (state == S_IDLE) && (!res_valid || res_ready);
  assign go        = cmd_valid && cmd_ready;
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);

  cdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd_item.data_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_next      = front;
    back_next       = back;
    pend_pop_next   = pend_pop;
    pend_front_next = pend_front;
    we              = 1'b0;
    waddr           = tail;
    re              = 1'b0;
    raddr           = wrap_inc(head);
    pop_go          = 1'b0;
    res_load        = 1'b0;
    res_next        = res_item;
    res_next.ok     = 1'b1;
    res_next.popped_value = NONE_WORD;

    if (state == S_IDLE) begin
      case (cmd_item.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            res_next.ok = 1'b0;
          end else begin
            we         = go;
            waddr      = wrap_dec(head);
            head_next  = wrap_dec(head);
            count_next = count + 1'b1;
            front_next = cmd_item.data_in;
            if (empty) begin
              back_next = cmd_item.data_in;
            end
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            res_next.ok = 1'b0;
          end else begin
            we         = go;
            waddr      = tail;
            tail_next  = wrap_inc(tail);
            count_next = count + 1'b1;
            back_next  = cmd_item.data_in;
            if (empty) begin
              front_next = cmd_item.data_in;
            end
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            res_next.ok = 1'b0;
          end else begin
            pop_go          = 1'b1;
            raddr           = wrap_inc(head);
            head_next       = wrap_inc(head);
            count_next      = count - 1'b1;
            pend_pop_next   = front;
            pend_front_next = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            res_next.ok = 1'b0;
          end else begin
            pop_go          = 1'b1;
            raddr           = wrap_dec(wrap_dec(tail));
            tail_next       = wrap_dec(tail);
            count_next      = count - 1'b1;
            pend_pop_next   = back;
            pend_front_next = 1'b0;
          end
        end
        default: begin
          res_next.ok = 1'b1;   // query; unused codes behave the same
        end
      endcase

      empty_next           = (count_next == '0);
      res_next.is_empty    = empty_next;
      res_next.is_full     = (count_next == FULL_CNT);
      res_next.front_value = empty_next ? NONE_WORD : front_next;
      res_next.back_value  = empty_next ? NONE_WORD : back_next;

      re = go && pop_go;
      if (go) begin
        if (pop_go) begin
          state_next = S_WAIT;
        end else begin
          res_load = 1'b1;
        end
      end else begin
        head_next  = head;
        tail_next  = tail;
        count_next = count;
        front_next = front;
        back_next  = back;
      end
    end else begin
      // read data now holds the word that becomes the new front or back
      empty_next = empty;
      if (pend_front) begin
        front_next = rdata;
      end else begin
        back_next = rdata;
      end
      res_next.ok           = 1'b1;
      res_next.popped_value = pend_pop;
      res_next.is_empty     = empty;
      res_next.is_full      = 1'b0;
      res_next.front_value  = empty ? NONE_WORD : front_next;
      res_next.back_value   = empty ? NONE_WORD : back_next;
      res_load              = 1'b1;
      state_next            = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front      <= front_next;
    back       <= back_next;
    pend_pop   <= pend_pop_next;
    pend_front <= pend_front_next;
    if (res_load) begin
      res_item <= res_next;
    end
  end

  // the output register is always free while a pop waits for its read
  a_wait_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !res_valid)
    else $error("result pending while pop read outstanding");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count beyond depth");

  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    (go && pop_go) |=> (state == S_WAIT) && (count == $past(count) - 1'b1))
    else $error("accepted pop did not enter read wait");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_item.is_empty && res_item.is_full))
    else $error("result both empty and full");

endmodule : circular_deque_core
`default_nettype wire
